@@ rtl/osle_pkg.sv @@
// ----------------------------------------------------------------------------
// osle_pkg
// Shared types and constants of the ordered static list engine: request and
// result items, command codes, controller states and control structs.
// ----------------------------------------------------------------------------
package osle_pkg;

    localparam int CAPACITY_DEF     = 16;
    localparam int KEY_BITS_DEF     = 32;
    localparam int PAYLOAD_BITS_DEF = 32;

    // fixed field widths of the request and result items
    localparam int FIELD_KEY_W = 32;
    localparam int FIELD_PAY_W = 32;
    localparam int FIELD_POS_W = 5;
    localparam int FIELD_CNT_W = 5;

    typedef enum logic [2:0] {
        CMD_APPEND       = 3'd0,
        CMD_PREPEND      = 3'd1,
        CMD_SORTED       = 3'd2,
        CMD_REMOVE_LAST  = 3'd3,
        CMD_REMOVE_FIRST = 3'd4,
        CMD_REMOVE_KEY   = 3'd5,
        CMD_READ_POS     = 3'd6,
        CMD_FIND         = 3'd7
    } cmd_t;

    typedef struct packed {
        cmd_t                           command;
        logic signed [FIELD_KEY_W-1:0]  entry_key;
        logic        [FIELD_PAY_W-1:0]  entry_payload;
        logic        [FIELD_POS_W-1:0]  slot_position;
    } in_item_t;

    typedef struct packed {
        logic                           success;
        logic signed [FIELD_KEY_W-1:0]  found_key;
        logic        [FIELD_PAY_W-1:0]  found_payload;
        logic        [FIELD_CNT_W-1:0]  entry_count;
        logic                           is_full;
        logic                           is_empty;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EXEC
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic scan_step;
        logic exec;
    } ctl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_done;
    } dp_stat_t;

endpackage

@@ rtl/osle_datapath.sv @@
// ----------------------------------------------------------------------------
// osle_datapath
// Row of slot cells with fill count, scan index and result register. Inserts
// and front or keyed removes shift the cells in parallel; searches step the index.
// ----------------------------------------------------------------------------
module osle_datapath #(
    parameter int CAPACITY     = osle_pkg::CAPACITY_DEF,
    parameter int KEY_BITS     = osle_pkg::KEY_BITS_DEF,
    parameter int PAYLOAD_BITS = osle_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  osle_pkg::ctl_cmd_t  ctl,
    output osle_pkg::dp_stat_t  stat,
    input  osle_pkg::in_item_t  in_item,
    output osle_pkg::out_item_t out_item
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > osle_pkg::FIELD_POS_W) ? CW : osle_pkg::FIELD_POS_W;

    logic [CW-1:0]           count_reg;
    logic [CW-1:0]           count_next;
    logic [CW-1:0]           idx_reg;
    osle_pkg::cmd_t          op_reg;
    logic [KEY_BITS-1:0]     key_reg;
    logic [PAYLOAD_BITS-1:0] pay_reg;
    logic [osle_pkg::FIELD_POS_W-1:0] pos_reg;
    logic [KEY_BITS-1:0]     key_cells_reg [CAPACITY];
    logic [PAYLOAD_BITS-1:0] pay_cells_reg [CAPACITY];
    logic [KEY_BITS-1:0]     up_key [CAPACITY];
    logic [PAYLOAD_BITS-1:0] up_pay [CAPACITY];
    logic [KEY_BITS-1:0]     dn_key [CAPACITY];
    logic [PAYLOAD_BITS-1:0] dn_pay [CAPACITY];
    osle_pkg::out_item_t     out_reg;
    osle_pkg::out_item_t     out_next;

    logic [63:0]             key_wide;
    logic [63:0]             pay_wide;
    logic [PW-1:0]           load_pos_m1;
    logic [CW-1:0]           load_idx;
    logic [KEY_BITS-1:0]     rd_key;
    logic [PAYLOAD_BITS-1:0] rd_pay;
    logic [63:0]             rd_key_wide;
    logic [63:0]             rd_pay_wide;
    logic                    at_end;
    logic                    cont_raw;
    logic                    not_full;
    logic                    not_empty;
    logic                    pos_ok;
    logic                    do_ins;
    logic                    do_dec;
    logic                    do_rem;
    logic                    do_read;
    logic [PW-1:0]           count_next_wide;

    // neighbor taps for the shift up and shift down moves
    for (genvar j = 0; j < CAPACITY; j++) begin : g_tap
        if (j == 0) begin : g_first
            assign up_key[j] = key_reg;
            assign up_pay[j] = pay_reg;
        end else begin : g_mid
            assign up_key[j] = key_cells_reg[j-1];
            assign up_pay[j] = pay_cells_reg[j-1];
        end
        if (j == CAPACITY - 1) begin : g_last
            assign dn_key[j] = key_cells_reg[j];
            assign dn_pay[j] = pay_cells_reg[j];
        end else begin : g_low
            assign dn_key[j] = key_cells_reg[j+1];
            assign dn_pay[j] = pay_cells_reg[j+1];
        end
    end

    // request capture: fit key and payload to the stored widths
    always_comb begin
        key_wide    = {{32{in_item.entry_key[31]}}, in_item.entry_key};
        pay_wide    = {32'b0, in_item.entry_payload};
        load_pos_m1 = PW'(in_item.slot_position) - PW'(1);
        case (in_item.command)
            osle_pkg::CMD_APPEND:   load_idx = count_reg;
            osle_pkg::CMD_READ_POS: load_idx = load_pos_m1[CW-1:0];
            default:                load_idx = '0;
        endcase
    end

    // scan: one slot per cycle through the read mux
    always_comb begin
        rd_key = key_cells_reg[idx_reg[IW-1:0]];
        rd_pay = pay_cells_reg[idx_reg[IW-1:0]];
        at_end = (idx_reg == count_reg);
        case (op_reg)
            osle_pkg::CMD_SORTED:     cont_raw = $signed(rd_key) < $signed(key_reg);
            osle_pkg::CMD_REMOVE_KEY: cont_raw = (rd_key != key_reg);
            osle_pkg::CMD_FIND:       cont_raw = (rd_key != key_reg);
            default:                  cont_raw = 1'b0;
        endcase
        stat.scan_done = !(!at_end && cont_raw);
    end

    // execute decision and result
    always_comb begin
        not_full  = (count_reg != CW'(CAPACITY));
        not_empty = (count_reg != '0);
        pos_ok    = (PW'(pos_reg) != '0) && (PW'(pos_reg) <= PW'(count_reg));
        do_ins    = 1'b0;
        do_dec    = 1'b0;
        do_rem    = 1'b0;
        do_read   = 1'b0;
        case (op_reg)
            osle_pkg::CMD_APPEND:       do_ins  = not_full;
            osle_pkg::CMD_PREPEND:      do_ins  = not_full;
            osle_pkg::CMD_SORTED:       do_ins  = not_full;
            osle_pkg::CMD_REMOVE_LAST:  do_dec  = not_empty;
            osle_pkg::CMD_REMOVE_FIRST: do_rem  = not_empty;
            osle_pkg::CMD_REMOVE_KEY:   do_rem  = !at_end;
            osle_pkg::CMD_READ_POS:     do_read = pos_ok;
            osle_pkg::CMD_FIND:         do_read = !at_end;
            default: ;
        endcase

        if (do_ins) begin
            count_next = count_reg + CW'(1);
        end else if (do_dec || do_rem) begin
            count_next = count_reg - CW'(1);
        end else begin
            count_next = count_reg;
        end
        count_next_wide = PW'(count_next);

        rd_key_wide = 64'(rd_key);
        rd_pay_wide = 64'(rd_pay);

        out_next.success       = do_ins || do_dec || do_rem || do_read;
        out_next.found_key     = do_read ? rd_key_wide[31:0] : '0;
        out_next.found_payload = do_read ? rd_pay_wide[31:0] : '0;
        out_next.entry_count   = count_next_wide[osle_pkg::FIELD_CNT_W-1:0];
        out_next.is_full       = (count_next == CW'(CAPACITY));
        out_next.is_empty      = (count_next == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (ctl.exec) begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            op_reg  <= in_item.command;
            key_reg <= key_wide[KEY_BITS-1:0];
            pay_reg <= pay_wide[PAYLOAD_BITS-1:0];
            pos_reg <= in_item.slot_position;
            idx_reg <= load_idx;
        end else if (ctl.scan_step) begin
            idx_reg <= idx_reg + CW'(1);
        end
        if (ctl.exec) begin
            out_reg <= out_next;
        end
    end

    // slot cells: insert shifts up from the index, remove shifts down
    always_ff @(posedge aclk) begin
        for (int j = 0; j < CAPACITY; j++) begin
            if (ctl.exec && do_ins) begin
                if (CW'(j) == idx_reg) begin
                    key_cells_reg[j] <= key_reg;
                    pay_cells_reg[j] <= pay_reg;
                end else if (CW'(j) > idx_reg) begin
                    key_cells_reg[j] <= up_key[j];
                    pay_cells_reg[j] <= up_pay[j];
                end
            end else if (ctl.exec && do_rem) begin
                if (CW'(j) >= idx_reg) begin
                    key_cells_reg[j] <= dn_key[j];
                    pay_cells_reg[j] <= dn_pay[j];
                end
            end
        end
    end

    assign out_item = out_reg;

endmodule

@@ rtl/osle_ctrl.sv @@
// ----------------------------------------------------------------------------
// osle_ctrl
// Sequencer of the list engine: takes a request, steps the scan, runs the
// update once the result register is free, and tracks result valid.
// ----------------------------------------------------------------------------
module osle_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    input  osle_pkg::dp_stat_t stat,
    output osle_pkg::ctl_cmd_t ctl
);

    osle_pkg::state_t state_reg;
    osle_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= osle_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        ctl        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            osle_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    ctl.load   = 1'b1;
                    state_next = osle_pkg::ST_SCAN;
                end
            end
            osle_pkg::ST_SCAN: begin
                if (stat.scan_done) begin
                    state_next = osle_pkg::ST_EXEC;
                end else begin
                    ctl.scan_step = 1'b1;
                end
            end
            osle_pkg::ST_EXEC: begin
                // wait until the previous result is gone
                if (!out_valid_reg || m_ready) begin
                    ctl.exec   = 1'b1;
                    state_next = osle_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = osle_pkg::ST_IDLE;
            end
        endcase

        if (ctl.exec) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    assign m_valid = out_valid_reg;

endmodule

@@ rtl/ordered_static_list_engine_unit.sv @@
// ----------------------------------------------------------------------------
// ordered_static_list_engine_unit
// Fixed-capacity list of keyed records with append, prepend, sorted insert,
// removes and lookups; one result per request.
// ----------------------------------------------------------------------------
//  channel   direction  handshake           payload
//  s_        in         s_valid / s_ready   s_data  (in_item_t)
//  m_        out        m_valid / m_ready   m_data  (out_item_t)
//
//  a request passes the idle (load), scan and exec states, and the scan steps over
//  at most the fill count of slots; the scan loop reads one slot a cycle
//  inserts and front or keyed removes shift the cells from the index up in parallel
//  reset clears the fill count and control only; slot cells are not cleared
//  the result register holds a result until taken; the next request is taken
//  meanwhile, and its update waits while the old result is still pending
// ----------------------------------------------------------------------------
module ordered_static_list_engine_unit #(
    parameter int CAPACITY     = osle_pkg::CAPACITY_DEF,
    parameter int KEY_BITS     = osle_pkg::KEY_BITS_DEF,
    parameter int PAYLOAD_BITS = osle_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  osle_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output osle_pkg::out_item_t m_data
);

    osle_pkg::ctl_cmd_t ctl;
    osle_pkg::dp_stat_t stat;

    osle_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .ctl     (ctl)
    );

    osle_datapath #(
        .CAPACITY     (CAPACITY),
        .KEY_BITS     (KEY_BITS),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (ctl),
        .stat     (stat),
        .in_item  (s_data),
        .out_item (m_data)
    );

    // one request in flight: busy right after a request is taken
    a_busy_after_accept : assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request taken while previous one still in work");

    // an update always lands in the result register
    a_exec_gives_result : assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.exec |=> m_valid)
        else $error("update done without a result");

    // empty flag agrees with the reported count
    a_empty_count : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.is_empty) |-> (m_data.entry_count == '0))
        else $error("empty flag with nonzero count");

endmodule
